### rtl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// Types, constants and helpers shared by the membrane mode potential block.
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int RADIUS_W = 16;
    localparam int ANGLE_W  = 16;
    localparam int POT_W    = 20;
    localparam int ORDER_W  = 3;
    localparam int ALPHA_W  = 21;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_ALPHA = 1'b1;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd0;
    localparam logic [ORDER_W-1:0] ORDER_MAX   = 3'd6;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 21'd157604;

    localparam logic [63:0] ONE_Q33     = 64'h0000_0002_0000_0000;
    localparam logic [63:0] ONE_Q30     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] MAG_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TWO_PI_Q46  = 64'd6746518852;
    localparam logic [63:0] EDGE_OFFSET = 64'd5570560;
    localparam logic [63:0] EDGE_DEN    = 64'd4394 << 32;
    localparam logic [63:0] EDGE_HALF   = 64'd4394 << 31;

    // edge divide by 4394 * 2^32: drop the low 32 bits, then multiply by
    // ceil(2^41 / 4394) and keep the bits above 41
    localparam logic [28:0] EDGE_RND   = 29'd2197;
    localparam logic [28:0] EDGE_RECIP = 29'd500460459;

    localparam logic [RADIUS_W-1:0] WALL_RADIUS = 16'd64226;
    localparam logic [RADIUS_W-1:0] EDGE_RADIUS = 16'd55706;
    localparam logic [POT_W-1:0]    POT_MAX     = 20'd655360;

    // rounding right shift applied after a product
    typedef enum logic [2:0] {
        SH0,
        SH16,
        SH30,
        SH33,
        SH50
    } mmp_shift_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        mmp_shift_t  shift;
    } mmp_mul_req_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } mmp_div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mmp_unit_rsp_t;

    function automatic logic [63:0] mmp_cap(input logic [63:0] v);
        return v[63] ? MAG_MAX : v;
    endfunction

    function automatic logic [POT_W-1:0] mmp_sat_pot(input logic [63:0] v);
        return (v > 64'(POT_MAX)) ? POT_MAX : v[POT_W-1:0];
    endfunction

endpackage

### rtl/mmp_if.sv
// ----------------------------------------------------------------------------
// mmp_if
// Handshake channels of the membrane mode potential block.
// ----------------------------------------------------------------------------
interface mmp_in_if import mmp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RADIUS_W-1:0] radius;
    logic [ANGLE_W-1:0]  angle;
    modport source (output valid, radius, angle, input ready);
    modport sink   (input valid, radius, angle, output ready);
endinterface

interface mmp_out_if import mmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POT_W-1:0] potential;
    logic             at_wall;
    modport source (output valid, potential, at_wall, input ready);
    modport sink   (input valid, potential, at_wall, output ready);
endinterface

interface mmp_cfg_if import mmp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/membrane_mode_potential.sv
// ----------------------------------------------------------------------------
// membrane_mode_potential
// Circular-membrane mode potential: power series Bessel sum, cosine factor,
// square and edge term, run on a shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
//  channel  | role   | payload
//  ---------+--------+----------------------------------------
//  cfg      | sink   | index, data (mode_order, mode_alpha)
//  sample   | sink   | radius, angle
//  result   | source | potential, at_wall
//
// One word at a time. A wall radius goes from acceptance straight to FINISH.
// Otherwise the word runs through the multiply and divide states on the
// four-pass multiplier and the restoring divider: up to TERM_LIMIT series
// terms, the cosine series when m > 0 and the edge term in the edge zone.
// sample.ready is high only while idle; a finished word waits in the output
// register, and a new word is taken meanwhile. FINISH stalls while that
// register is full. cfg is always ready.
// ----------------------------------------------------------------------------
module membrane_mode_potential import mmp_pkg::*;
#(
    parameter int TERM_LIMIT = 25
)
(
    input  logic      clk,
    input  logic      rst_n,
    mmp_cfg_if.sink   cfg,
    mmp_in_if.sink    sample,
    mmp_out_if.source result
);

    localparam int CNT_BITS = $clog2(TERM_LIMIT + 1);
    localparam int CW       = (CNT_BITS > 4) ? CNT_BITS : 4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_Q,
        S_INIT_MUL,
        S_INIT_DIV,
        S_ACC,
        S_TERM_MUL,
        S_TERM_DIV,
        S_JM,
        S_TH_MUL,
        S_T2_MUL,
        S_CT_MUL,
        S_CT_DIV,
        S_V_MUL,
        S_P_MUL,
        S_D2_MUL,
        S_D3_MUL,
        S_EDGE,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic                  issued_reg, issued_next;
    logic [ORDER_W-1:0]    mode_order_reg, mode_order_next;
    logic [ALPHA_W-1:0]    mode_alpha_reg, mode_alpha_next;
    logic [RADIUS_W-1:0]   radius_reg, radius_next;
    logic [ANGLE_W-1:0]    phase_reg, phase_next;
    logic [ORDER_W-1:0]    m_reg, m_next;
    logic [63:0]           h_reg, h_next;
    logic [63:0]           q_reg, q_next;
    logic [63:0]           t_reg, t_next;
    logic [63:0]           tmp_reg, tmp_next;
    logic signed [63:0]    acc_reg, acc_next;
    logic [63:0]           jm_reg, jm_next;
    logic [30:0]           c_reg, c_next;
    logic [POT_W-1:0]      p_reg, p_next;
    logic                  wall_reg, wall_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [POT_W-1:0]      out_pot_reg, out_pot_next;
    logic                  out_wall_reg, out_wall_next;

    mmp_mul_req_t          mul_req;
    mmp_div_req_t          div_req;
    mmp_unit_rsp_t         mul_rsp;
    mmp_unit_rsp_t         div_rsp;

    logic [ORDER_W-1:0]    m_in;
    logic [18:0]           phase_full;
    logic [36:0]           h_full;
    logic [CW:0]           kp1;
    logic [CW:0]           kpm;
    logic [63:0]           den_term;
    logic [4:0]            two_i;
    logic [5:0]            lo_f;
    logic [63:0]           den_cos;
    logic [63:0]           den_sel;
    logic [63:0]           d_edge;
    logic [28:0]           edge_y;
    logic [57:0]           edge_prod;
    logic                  use_sin;
    logic signed [64:0]    bes_sum;
    logic signed [64:0]    bes_diff;
    logic signed [63:0]    cos_sum;
    logic                  in_fire;

    mmp_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
    mmp_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign sample.ready    = (state_reg == S_IDLE);
    assign in_fire         = sample.valid && sample.ready;
    assign cfg.ready       = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.potential = out_pot_reg;
    assign result.at_wall  = out_wall_reg;

    assign m_in       = (mode_order_reg > ORDER_MAX) ? ORDER_MAX : mode_order_reg;
    assign phase_full = m_in * sample.angle;
    assign h_full     = mode_alpha_reg * sample.radius;
    assign use_sin    = phase_reg[14];

    // series divisor k*(k+m) with k = cnt+1
    assign kp1      = {1'b0, cnt_reg} + {{CW{1'b0}}, 1'b1};
    assign kpm      = kp1 + {{(CW + 1 - ORDER_W){1'b0}}, m_reg};
    assign den_term = 64'(kp1) * 64'(kpm);

    // cosine divisor (2i-1)(2i), sine divisor 2i(2i+1)
    assign two_i   = {cnt_reg[3:0], 1'b0};
    assign lo_f    = use_sin ? {1'b0, two_i} : ({1'b0, two_i} - 6'd1);
    assign den_cos = 64'(lo_f) * 64'(lo_f + 6'd1);

    assign d_edge  = 64'(radius_reg) * 64'd100 - EDGE_OFFSET;

    // rounded edge quotient: the cube stays below 2^60
    assign edge_y    = tmp_reg[60:32] + EDGE_RND;
    assign edge_prod = 58'(edge_y) * 58'(EDGE_RECIP);

    assign bes_sum  = {acc_reg[63], acc_reg} + $signed({1'b0, t_reg});
    assign bes_diff = {acc_reg[63], acc_reg} - $signed({1'b0, t_reg});

    always_comb
    begin
        unique case (state_reg)
            S_INIT_DIV: den_sel = 64'(cnt_reg);
            S_CT_DIV:   den_sel = den_cos;
            default:    den_sel = den_term;
        endcase
    end

    // operand selection for the shared units
    always_comb
    begin
        mul_req = '{start: 1'b0, a: h_reg, b: h_reg, shift: SH33};
        div_req = '{start: 1'b0, num: mmp_cap(tmp_reg) + (den_sel >> 1), den: den_sel};
        unique case (state_reg)
            S_Q:        mul_req.start = !issued_reg;
            S_INIT_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = t_reg;
            end
            S_TERM_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = t_reg;
                mul_req.b     = q_reg;
            end
            S_TH_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = {50'd0, phase_reg[13:0]};
                mul_req.b     = TWO_PI_Q46;
                mul_req.shift = SH16;
            end
            S_T2_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = t_reg;
                mul_req.b     = t_reg;
                mul_req.shift = SH30;
            end
            S_CT_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = t_reg;
                mul_req.b     = q_reg;
                mul_req.shift = SH30;
            end
            S_V_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = jm_reg;
                mul_req.b     = {33'd0, c_reg};
                mul_req.shift = SH30;
            end
            S_P_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = tmp_reg;
                mul_req.b     = tmp_reg;
                mul_req.shift = SH50;
            end
            S_D2_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = d_edge;
                mul_req.b     = d_edge;
                mul_req.shift = SH0;
            end
            S_D3_MUL:
            begin
                mul_req.start = !issued_reg;
                mul_req.a     = tmp_reg;
                mul_req.b     = d_edge;
                mul_req.shift = SH0;
            end
            S_INIT_DIV, S_TERM_DIV, S_CT_DIV: div_req.start = !issued_reg;
            default:    mul_req.start = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_order_next = mode_order_reg;
        mode_alpha_next = mode_alpha_reg;
        radius_next     = radius_reg;
        phase_next      = phase_reg;
        m_next          = m_reg;
        h_next          = h_reg;
        q_next          = q_reg;
        t_next          = t_reg;
        tmp_next        = tmp_reg;
        acc_next        = acc_reg;
        jm_next         = jm_reg;
        c_next          = c_reg;
        p_next          = p_reg;
        wall_next       = wall_reg;
        cnt_next        = cnt_reg;
        out_pot_next    = out_pot_reg;
        out_wall_next   = out_wall_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        cos_sum         = cnt_reg[0] ? (acc_reg - $signed(div_rsp.result))
                                     : (acc_reg + $signed(div_rsp.result));

        issued_next = issued_reg;
        if (mul_req.start || div_req.start)
            issued_next = 1'b1;
        else if (mul_rsp.done || div_rsp.done)
            issued_next = 1'b0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MODE_ORDER: mode_order_next = cfg.data[ORDER_W-1:0];
                CFG_MODE_ALPHA: mode_alpha_next = cfg.data[ALPHA_W-1:0];
                default:        mode_order_next = mode_order_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    radius_next = sample.radius;
                    phase_next  = phase_full[ANGLE_W-1:0];
                    m_next      = m_in;
                    h_next      = {27'd0, h_full};
                    t_next      = ONE_Q33;
                    acc_next    = '0;
                    cnt_next    = CW'(1);
                    if (sample.radius >= WALL_RADIUS)
                    begin
                        p_next     = POT_MAX;
                        wall_next  = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        wall_next  = 1'b0;
                        state_next = S_Q;
                    end
                end
            end
            S_Q:
            begin
                if (mul_rsp.done)
                begin
                    q_next = mmp_cap(mul_rsp.result);
                    if (m_reg == '0)
                    begin
                        cnt_next   = '0;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        state_next = S_INIT_MUL;
                    end
                end
            end
            S_INIT_MUL:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next   = mul_rsp.result;
                    state_next = S_INIT_DIV;
                end
            end
            S_INIT_DIV:
            begin
                if (div_rsp.done)
                begin
                    t_next = div_rsp.result;
                    if (cnt_reg == CW'(m_reg))
                    begin
                        cnt_next   = '0;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = S_INIT_MUL;
                    end
                end
            end
            S_ACC:
            begin
                // add even terms, subtract odd ones, saturate at +-MAG_MAX
                if (!cnt_reg[0])
                    acc_next = (bes_sum > $signed({1'b0, MAG_MAX}))
                             ? $signed(MAG_MAX) : bes_sum[63:0];
                else
                    acc_next = (bes_diff < -$signed({1'b0, MAG_MAX}))
                             ? -$signed(MAG_MAX) : bes_diff[63:0];
                if ((t_reg == '0) || (cnt_reg == CW'(TERM_LIMIT - 1)))
                    state_next = S_JM;
                else
                    state_next = S_TERM_MUL;
            end
            S_TERM_MUL:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next   = mul_rsp.result;
                    state_next = S_TERM_DIV;
                end
            end
            S_TERM_DIV:
            begin
                if (div_rsp.done)
                begin
                    t_next     = div_rsp.result;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_ACC;
                end
            end
            S_JM:
            begin
                jm_next = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
                if (m_reg == '0)
                begin
                    c_next     = ONE_Q30[30:0];
                    state_next = S_V_MUL;
                end
                else
                begin
                    state_next = S_TH_MUL;
                end
            end
            S_TH_MUL:
            begin
                if (mul_rsp.done)
                begin
                    t_next     = mul_rsp.result;
                    state_next = S_T2_MUL;
                end
            end
            S_T2_MUL:
            begin
                if (mul_rsp.done)
                begin
                    q_next     = mul_rsp.result;
                    t_next     = use_sin ? t_reg : ONE_Q30;
                    acc_next   = use_sin ? $signed(t_reg) : $signed(ONE_Q30);
                    cnt_next   = CW'(1);
                    state_next = S_CT_MUL;
                end
            end
            S_CT_MUL:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next   = mul_rsp.result;
                    state_next = S_CT_DIV;
                end
            end
            S_CT_DIV:
            begin
                if (div_rsp.done)
                begin
                    t_next   = div_rsp.result;
                    acc_next = cos_sum;
                    if (cnt_reg == CW'(8))
                    begin
                        // clamp to [0, 1.0]
                        if (cos_sum < 0)
                            c_next = '0;
                        else if (cos_sum > $signed(ONE_Q30))
                            c_next = ONE_Q30[30:0];
                        else
                            c_next = cos_sum[30:0];
                        state_next = S_V_MUL;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = S_CT_MUL;
                    end
                end
            end
            S_V_MUL:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next   = mmp_cap(mul_rsp.result);
                    state_next = S_P_MUL;
                end
            end
            S_P_MUL:
            begin
                if (mul_rsp.done)
                begin
                    p_next     = mmp_sat_pot(mul_rsp.result);
                    state_next = (radius_reg >= EDGE_RADIUS) ? S_D2_MUL : S_FINISH;
                end
            end
            S_D2_MUL:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next   = mul_rsp.result;
                    state_next = S_D3_MUL;
                end
            end
            S_D3_MUL:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next   = mul_rsp.result;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                p_next     = mmp_sat_pot(64'(p_reg) + 64'(edge_prod[57:41]));
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pot_next   = p_reg;
                    out_wall_next  = wall_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issued_reg     <= 1'b0;
            mode_order_reg <= ORDER_RESET;
            mode_alpha_reg <= ALPHA_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issued_reg     <= issued_next;
            mode_order_reg <= mode_order_next;
            mode_alpha_reg <= mode_alpha_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radius_reg   <= radius_next;
        phase_reg    <= phase_next;
        m_reg        <= m_next;
        h_reg        <= h_next;
        q_reg        <= q_next;
        t_reg        <= t_next;
        tmp_reg      <= tmp_next;
        acc_reg      <= acc_next;
        jm_reg       <= jm_next;
        c_reg        <= c_next;
        p_reg        <= p_next;
        wall_reg     <= wall_next;
        cnt_reg      <= cnt_next;
        out_pot_reg  <= out_pot_next;
        out_wall_reg <= out_wall_next;
    end

`ifndef SYNTHESIS
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_rsp.done, div_rsp.done}))
        else $error("multiplier and divider finished together");

    a_accept_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !issued_reg)
        else $error("word accepted while a unit operation is pending");

    a_pot_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.potential <= POT_MAX))
        else $error("potential above saturation value");

    a_wall_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.at_wall) |-> (result.potential == POT_MAX))
        else $error("wall word without wall value");
`endif

endmodule

### rtl/mmp_mul.sv
// ----------------------------------------------------------------------------
// mmp_mul
// 64x64 multiplier built from one 32x32 unit over four partial products,
// followed by a rounding right shift with saturation to 64 bits.
// ----------------------------------------------------------------------------
module mmp_mul import mmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  mmp_mul_req_t  req,
    output mmp_unit_rsp_t rsp
);

    logic          busy_reg;
    logic          done_reg;
    logic [2:0]    step_reg;
    logic [63:0]   a_reg;
    logic [63:0]   b_reg;
    mmp_shift_t    shift_reg;
    logic [127:0]  prod_reg;
    logic [63:0]   res_reg;

    logic [31:0]   a_half;
    logic [31:0]   b_half;
    logic [63:0]   pp;
    logic [127:0]  pp_aligned;
    logic [127:0]  rnd;
    logic [127:0]  rsum;
    logic [127:0]  shifted;
    logic [63:0]   sat;

    assign a_half = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = step_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign pp     = a_half * b_half;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    pp_aligned = {64'd0, pp};
            2'd3:    pp_aligned = {pp, 64'd0};
            default: pp_aligned = {32'd0, pp, 32'd0};
        endcase
    end

    always_comb
    begin
        case (shift_reg)
            SH16:    rnd = 128'd1 << 15;
            SH30:    rnd = 128'd1 << 29;
            SH33:    rnd = 128'd1 << 32;
            SH50:    rnd = 128'd1 << 49;
            default: rnd = 128'd0;
        endcase
        rsum = prod_reg + rnd;
        case (shift_reg)
            SH16:    shifted = rsum >> 16;
            SH30:    shifted = rsum >> 30;
            SH33:    shifted = rsum >> 33;
            SH50:    shifted = rsum >> 50;
            default: shifted = rsum;
        endcase
        sat = (|shifted[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : shifted[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg     <= req.a;
            b_reg     <= req.b;
            shift_reg <= req.shift;
            prod_reg  <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 3'd4)
                res_reg <= sat;
            else
                prod_reg <= prod_reg + pp_aligned;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

### rtl/mmp_div.sv
// ----------------------------------------------------------------------------
// mmp_div
// Restoring 64-bit by 64-bit unsigned divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mmp_div import mmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  mmp_div_req_t  req,
    output mmp_unit_rsp_t rsp
);

    logic         busy_reg;
    logic         done_reg;
    logic [5:0]   cnt_reg;
    logic [63:0]  quo_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  den_reg;

    logic [64:0]  trial;
    logic [64:0]  diff;
    logic         fits;

    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= 64'd0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[62:0], fits};
            rem_reg <= fits ? diff[63:0] : trial[63:0];
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;

endmodule

### test/tb_mmp_if.sv
// ----------------------------------------------------------------------------
// tb_mmp_if
// Interfaces come from the RTL interface file; nothing extra is needed for the
// bench here beyond a shared result record used by the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tb_mmp_pkg;
    import mmp_pkg::*;

    typedef struct {
        logic [POT_W-1:0] potential;
        logic             at_wall;
    } mode_result_t;
endpackage

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives radius/angle words into the membrane mode potential block under a
// range of mode settings, idling and stall patterns, predicts each potential with an
// independent fixed-point Bessel/cosine model and checks every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    import mmp_pkg::*;
    import tb_mmp_pkg::*;

    class potential_scoreboard;
        logic [ORDER_W-1:0] order_reg;
        logic [ALPHA_W-1:0] alpha_reg;
        mode_result_t       pending_q[$];
        int                 errors;

        function new();
            order_reg = ORDER_RESET;
            alpha_reg = ALPHA_RESET;
            errors    = 0;
        endfunction

        function logic [63:0] rnd_mul(logic [63:0] a, logic [63:0] b, int s);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            p = (p + (128'd1 << (s - 1))) >> s;
            return (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
        endfunction

        function logic [63:0] clip(logic [63:0] v);
            return (v > MAG_MAX) ? MAG_MAX : v;
        endfunction

        function logic [63:0] rnd_div(logic [63:0] v, logic [63:0] d);
            return (clip(v) + d / 2) / d;
        endfunction

        // |J_m(2h)| in Q.33
        function logic [63:0] bessel_abs(logic [63:0] h, int m);
            logic [63:0] q;
            logic [63:0] t;
            longint      acc;
            longint      top;
            q   = clip(rnd_mul(h, h, 33));
            t   = ONE_Q33;
            acc = 0;
            top = longint'(MAG_MAX);
            for (int i = 1; i <= m; i++)
                t = rnd_div(rnd_mul(t, h, 33), 64'(i));
            for (int k = 0; k < 25; k++)
            begin
                if ((k % 2) == 0)
                begin
                    if (acc > top - longint'(t))
                        acc = top;
                    else
                        acc = acc + longint'(t);
                end
                else
                begin
                    if (acc < -top + longint'(t))
                        acc = -top;
                    else
                        acc = acc - longint'(t);
                end
                if (t == 0)
                    break;
                t = rnd_div(rnd_mul(t, q, 33), 64'((k + 1) * (k + 1 + m)));
            end
            return (acc < 0) ? 64'(-acc) : 64'(acc);
        endfunction

        // |cos| of a 16-bit turn fraction, Q.30
        function logic [63:0] cos_abs(logic [15:0] phase);
            logic [63:0] f;
            logic [63:0] th;
            logic [63:0] t2;
            logic [63:0] term;
            logic [63:0] den;
            logic        odd_quad;
            longint      sum;
            f        = 64'(phase[13:0]);
            odd_quad = phase[14];
            th   = (f * TWO_PI_Q46 + (64'd1 << 15)) >> 16;
            t2   = (th * th + (64'd1 << 29)) >> 30;
            term = odd_quad ? th : ONE_Q30;
            sum  = longint'(term);
            for (int i = 1; i <= 8; i++)
            begin
                den  = odd_quad ? 64'((2 * i) * (2 * i + 1)) : 64'((2 * i - 1) * (2 * i));
                term = (term * t2 + (64'd1 << 29)) >> 30;
                term = (term + den / 2) / den;
                if (i % 2)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                return '0;
            if (64'(sum) > ONE_Q30)
                return ONE_Q30;
            return 64'(sum);
        endfunction

        function void note(logic [RADIUS_W-1:0] radius, logic [ANGLE_W-1:0] angle);
            mode_result_t exp_res;
            int           m;
            logic [63:0]  jm;
            logic [63:0]  c;
            logic [63:0]  v;
            logic [63:0]  p;
            logic [63:0]  d;
            m = (order_reg > ORDER_MAX) ? int'(ORDER_MAX) : int'(order_reg);
            if (radius >= WALL_RADIUS)
            begin
                exp_res.potential = POT_MAX;
                exp_res.at_wall   = 1'b1;
            end
            else
            begin
                jm = bessel_abs(64'(alpha_reg) * 64'(radius), m);
                c  = (m == 0) ? ONE_Q30 : cos_abs(16'(64'(m) * 64'(angle)));
                v  = clip(rnd_mul(jm, c, 30));
                p  = rnd_mul(v, v, 50);
                if (p > 64'(POT_MAX))
                    p = 64'(POT_MAX);
                if (radius >= EDGE_RADIUS)
                begin
                    d = 64'(radius) * 100 - EDGE_OFFSET;
                    p = p + (d * d * d + EDGE_HALF) / EDGE_DEN;
                    if (p > 64'(POT_MAX))
                        p = 64'(POT_MAX);
                end
                exp_res.potential = p[POT_W-1:0];
                exp_res.at_wall   = 1'b0;
            end
            pending_q.push_back(exp_res);
        endfunction

        function void check(logic [POT_W-1:0] potential, logic at_wall);
            mode_result_t exp_res;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result word: potential %0d at_wall %0d", potential, at_wall);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (potential !== exp_res.potential)
            begin
                $error("potential: expected %0d, got %0d", exp_res.potential, potential);
                errors++;
            end
            if (at_wall !== exp_res.at_wall)
            begin
                $error("at_wall: expected %0d, got %0d", exp_res.at_wall, at_wall);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mmp_cfg_if cfg_ch ();
    mmp_in_if  sample_ch ();
    mmp_out_if result_ch ();

    membrane_mode_potential dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .sample (sample_ch.sink),
        .result (result_ch.source)
    );

    potential_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_reqs;
    int hold_done;
    int hold_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_reqs != hold_done)
        begin
            hold_done = hold_reqs;
            hold_left = 8000;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready = 1'b0;
        end
        else
            result_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check(result_ch.potential, result_ch.at_wall);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_MODE_ORDER)
            sb.order_reg = value[ORDER_W-1:0];
        else
            sb.alpha_reg = value[ALPHA_W-1:0];
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_word(logic [RADIUS_W-1:0] radius, logic [ANGLE_W-1:0] angle);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid  = 1'b1;
        sample_ch.radius = radius;
        sample_ch.angle  = angle;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note(radius, angle);
        @(negedge clk);
    endtask

    task automatic drain();
        sample_ch.valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [RADIUS_W-1:0] pick_radius();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return RADIUS_W'($urandom_range(64226, 65535));
        if (sel < 30)
            return RADIUS_W'($urandom_range(55706, 64225));
        if (sel < 35)
            return RADIUS_W'($urandom_range(0, 255));
        return RADIUS_W'($urandom_range(0, 55705));
    endfunction

    logic [ORDER_W-1:0] order_set[6];
    logic [ALPHA_W-1:0] alpha_set[6];
    int                 idle_set[4];
    int                 stall_set[4];

    initial
    begin
        sb        = new();
        idle_pct  = 0;
        stall_pct = 0;
        hold_reqs = 0;
        rst_n            = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_MODE_ORDER;
        cfg_ch.data      = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.radius = '0;
        sample_ch.angle  = '0;
        order_set = '{3'd0, 3'd6, 3'd7, 3'd1, 3'd3, 3'd2};
        alpha_set = '{ALPHA_RESET, 21'd1572864, 21'd0, 21'h1FFFFF, 21'd400000, 21'd0};
        idle_set  = '{0, 85, 0, 11};
        stall_set = '{0, 0, 85, 11};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            // last setting uses a random mode; the first keeps the reset values
            if (ph == 5)
            begin
                order_set[5] = ORDER_W'($urandom_range(0, 7));
                alpha_set[5] = ALPHA_W'($urandom_range(0, 1572864));
            end
            if (ph > 0)
            begin
                write_reg(CFG_MODE_ORDER, CFG_DATA_W'(order_set[ph]));
                write_reg(CFG_MODE_ALPHA, alpha_set[ph]);
            end
            idle_pct  = 0;
            stall_pct = 0;
            // directed: extremes of radius and angle, boundaries of both zones
            send_word(16'd0, 16'd0);
            send_word(16'd65535, 16'hFFFF);
            send_word(16'd64226, 16'h4000);
            send_word(16'd64225, 16'h8000);
            send_word(16'd55706, 16'h2AAA);
            send_word(16'd55705, 16'hC001);
            if (ph == 0)
            begin
                drain();
                hold_reqs = hold_reqs + 1;
                // keep offering while the result side is held off
                for (int n = 0; n < 6; n++)
                    send_word(pick_radius(), 16'($urandom()));
            end
            for (int ip = 0; ip < 4; ip++)
            begin
                idle_pct  = idle_set[ip];
                stall_pct = stall_set[ip];
                for (int n = 0; n < 25; n++)
                    send_word(pick_radius(), 16'($urandom()));
            end
            stall_pct = 0;
            drain();
        end
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("membrane_mode_potential: match");
        else
            $display("membrane_mode_potential: mismatch");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("membrane_mode_potential: mismatch");
        $finish;
    end
endmodule

### sim.f
rtl/mmp_pkg.sv
rtl/mmp_if.sv
rtl/mmp_mul.sv
rtl/mmp_div.sv
rtl/membrane_mode_potential.sv
test/tb_mmp_if.sv
test/tb_top.sv
